/* hw/rtl/wgs_pkg.sv */
// ----------------------------------------------------------------------------
// Waypoint guidance step package
// Shared constants, configuration register indexes, the square path table and
// the command and status types between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wgs_pkg;

    localparam int NUM_WAYPOINTS = 5;
    localparam int IDX_W         = 3;

    // Iteration counts of the shared sequential units.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int CNT_W      = 5;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_CAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_THR = 2'd2;

    localparam logic [30:0] ACCEL_CAP_RST  = 31'd327680;
    localparam logic [31:0] STEP_GAIN_RST  = 32'd429497;
    localparam logic [15:0] ARRIVE_THR_RST = 16'd1;
    localparam logic [IDX_W-1:0] WP_IDX_RST = 3'd1;

    // Half of the 4.0 segment length in Q16.16.
    localparam logic [32:0] HALF_SEG = 33'd131072;

    typedef struct packed {
        logic load;
        logic square;
        logic radicand;
        logic sqrt_step;
        logic alpha;
        logic mul_m;
        logic div_step;
        logic div_first;
        logic mul_lo;
        logic mul_hi;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

    // Corners of the closed square path, integer coordinates.
    function automatic logic [2:0] wp_x(input logic [1:0] k);
        logic [2:0] v;
        unique case (k)
            2'd0:    v = 3'd1;
            2'd1:    v = 3'd5;
            2'd2:    v = 3'd5;
            default: v = 3'd1;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] wp_y(input logic [1:0] k);
        logic [2:0] v;
        unique case (k)
            2'd0:    v = 3'd1;
            2'd1:    v = 3'd1;
            2'd2:    v = 3'd5;
            default: v = 3'd5;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/wgs_controller.sv */
// ----------------------------------------------------------------------------
// Waypoint guidance step controller
// Sequences one item through square, square root, scale, divide, multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wgs_controller
    import wgs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire logic    i_out_stall,
    input  wire t_status i_status,
    output logic         o_stall,
    output t_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQUARE, S_RADICAND, S_SQRT, S_ALPHA,
        S_MUL_M, S_DIV, S_MUL_LO, S_MUL_HI, S_FINISH
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_can_finish;

    assign w_can_finish = !(i_status.out_full && i_out_stall);
    assign o_stall      = (r_state != S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_valid;
        o_cmd.square    = (r_state == S_SQUARE);
        o_cmd.radicand  = (r_state == S_RADICAND);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.alpha     = (r_state == S_ALPHA);
        o_cmd.mul_m     = (r_state == S_MUL_M);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.div_first = (r_state == S_DIV) && (r_cnt == '0);
        o_cmd.mul_lo    = (r_state == S_MUL_LO);
        o_cmd.mul_hi    = (r_state == S_MUL_HI);
        o_cmd.finish    = (r_state == S_FINISH) && w_can_finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_SQUARE;
                end
                S_SQUARE:   r_state <= S_RADICAND;
                S_RADICAND: begin
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) r_state <= S_ALPHA;
                end
                S_ALPHA:    r_state <= S_MUL_M;
                S_MUL_M: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) r_state <= S_MUL_LO;
                end
                S_MUL_LO:   r_state <= S_MUL_HI;
                S_MUL_HI:   r_state <= S_FINISH;
                S_FINISH: begin
                    if (w_can_finish) r_state <= S_IDLE;
                end
                default:    r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/wgs_datapath.sv */
// ----------------------------------------------------------------------------
// Waypoint guidance step datapath
// Offset, restoring square root, two restoring dividers, scaling multipliers,
// saturating velocity update, waypoint index and configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wgs_datapath
    import wgs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]           i_cfg_data,
    input  wire logic signed [31:0]    i_pos_x,
    input  wire logic signed [31:0]    i_pos_y,
    input  wire logic signed [31:0]    i_vel_x,
    input  wire logic signed [31:0]    i_vel_y,
    input  wire logic                  i_out_stall,
    output t_status                    o_status,
    output logic                       o_valid,
    output logic signed [31:0]         o_new_vel_x,
    output logic signed [31:0]         o_new_vel_y,
    output logic [IDX_W-1:0]           o_target_index,
    output logic                       o_reached
);

    logic [30:0]       r_accel_cap;
    logic [31:0]       r_step_gain;
    logic [15:0]       r_arrive_thr;
    logic [IDX_W-1:0]  r_wp_idx;

    logic [31:0]        r_ax, r_ay;
    logic               r_negx, r_negy;
    logic signed [31:0] r_velx, r_vely;
    logic [63:0]        r_sqx, r_sqy, r_rad;
    logic [30:0]        r_gc;
    logic [33:0]        r_srem;
    logic [31:0]        r_root;
    logic               r_dzero, r_hit;
    logic [30:0]        r_amag;
    logic               r_aneg;
    logic [45:0]        r_mmag;
    logic [32:0]        r_remx, r_remy;
    logic [30:0]        r_qx, r_qy;
    logic [32:0]        r_plox, r_ploy;
    logic [44:0]        r_phix, r_phiy;

    logic               r_out_valid;
    logic signed [31:0] r_out_vx, r_out_vy;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_hit;

    // Offset to the current target.
    logic signed [33:0] w_tx, w_ty, w_dx, w_dy, w_mdx, w_mdy;
    assign w_tx  = $signed({15'd0, wp_x(r_wp_idx[1:0]), 16'd0});
    assign w_ty  = $signed({15'd0, wp_y(r_wp_idx[1:0]), 16'd0});
    assign w_dx  = w_tx - {{2{i_pos_x[31]}}, i_pos_x};
    assign w_dy  = w_ty - {{2{i_pos_y[31]}}, i_pos_y};
    assign w_mdx = w_dx[33] ? -w_dx : w_dx;
    assign w_mdy = w_dy[33] ? -w_dy : w_dy;

    // One square root digit per cycle.
    logic [35:0] w_scand, w_strial;
    assign w_scand  = {r_srem, r_rad[63:62]};
    assign w_strial = {2'b00, r_root, 2'b01};

    // Offset from half the segment gives alpha = (2d - L) / L in Q16.16.
    logic signed [32:0] w_e, w_me;
    assign w_e  = $signed({1'b0, r_root}) - $signed(HALF_SEG);
    assign w_me = w_e[32] ? -w_e : w_e;

    logic [61:0] w_gcprod, w_mprod;
    assign w_gcprod = 62'(({32'd0, r_accel_cap} * {31'd0, r_step_gain}) >> 32);
    assign w_mprod  = r_gc * r_amag;

    // Divider steps; the first brings in the numerator bit without a shift.
    logic [33:0] w_cx, w_cy, w_div;
    assign w_div = {2'b00, r_root};
    assign w_cx  = i_cmd.div_first ? {1'b0, r_remx} : {r_remx, 1'b0};
    assign w_cy  = i_cmd.div_first ? {1'b0, r_remy} : {r_remy, 1'b0};

    logic [62:0] w_lox, w_loy;
    assign w_lox = r_mmag[31:0] * r_qx;
    assign w_loy = r_mmag[31:0] * r_qy;

    // Final combine, sign and saturation.
    logic [47:0]        w_rx, w_ry;
    logic signed [48:0] w_dvx, w_dvy, w_sx, w_sy;
    logic signed [31:0] w_satx, w_saty;
    logic [IDX_W-1:0]   w_nidx, w_adv;
    assign w_rx  = {1'b0, r_phix, 2'b00} + {15'd0, r_plox};
    assign w_ry  = {1'b0, r_phiy, 2'b00} + {15'd0, r_ploy};
    assign w_dvx = r_dzero ? '0 :
                   ((r_aneg ^ r_negx) ? -$signed({1'b0, w_rx}) : $signed({1'b0, w_rx}));
    assign w_dvy = r_dzero ? '0 :
                   ((r_aneg ^ r_negy) ? -$signed({1'b0, w_ry}) : $signed({1'b0, w_ry}));
    assign w_sx  = {{17{r_velx[31]}}, r_velx} + w_dvx;
    assign w_sy  = {{17{r_vely[31]}}, r_vely} + w_dvy;

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v[48:31] == '0 || v[48:31] == '1) r = v[31:0];
        else if (v[48])                       r = 32'sh8000_0000;
        else                                  r = 32'sh7fff_ffff;
        return r;
    endfunction

    assign w_satx = sat32(w_sx);
    assign w_saty = sat32(w_sy);
    assign w_nidx = r_wp_idx + 1'b1;
    assign w_adv  = (w_nidx >= IDX_W'(NUM_WAYPOINTS)) ? WP_IDX_RST : w_nidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_cap  <= ACCEL_CAP_RST;
            r_step_gain  <= STEP_GAIN_RST;
            r_arrive_thr <= ARRIVE_THR_RST;
            r_wp_idx     <= WP_IDX_RST;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ACCEL_CAP:  r_accel_cap  <= i_cfg_data[30:0];
                    CFG_STEP_GAIN:  r_step_gain  <= i_cfg_data;
                    CFG_ARRIVE_THR: r_arrive_thr <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_hit) r_wp_idx <= w_adv;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax   <= w_mdx[31:0];
            r_ay   <= w_mdy[31:0];
            r_negx <= w_dx[33];
            r_negy <= w_dy[33];
            r_velx <= i_vel_x;
            r_vely <= i_vel_y;
        end
        if (i_cmd.square) begin
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
        end
        if (i_cmd.radicand) begin
            r_rad  <= r_sqx + r_sqy;
            r_gc   <= w_gcprod[30:0];
            r_srem <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (w_scand >= w_strial) begin
                r_srem <= 34'(w_scand - w_strial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_srem <= w_scand[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
        end
        if (i_cmd.alpha) begin
            r_amag  <= w_me[31:1];
            r_aneg  <= w_e[32];
            r_dzero <= (r_root == '0);
            r_hit   <= (r_root < {16'd0, r_arrive_thr});
            r_remx  <= {1'b0, r_ax};
            r_remy  <= {1'b0, r_ay};
            r_qx    <= '0;
            r_qy    <= '0;
        end
        if (i_cmd.mul_m) begin
            r_mmag <= w_mprod[61:16];
        end
        if (i_cmd.div_step) begin
            if (w_cx >= w_div) begin
                r_remx <= 33'(w_cx - w_div);
                r_qx   <= {r_qx[29:0], 1'b1};
            end else begin
                r_remx <= w_cx[32:0];
                r_qx   <= {r_qx[29:0], 1'b0};
            end
            if (w_cy >= w_div) begin
                r_remy <= 33'(w_cy - w_div);
                r_qy   <= {r_qy[29:0], 1'b1};
            end else begin
                r_remy <= w_cy[32:0];
                r_qy   <= {r_qy[29:0], 1'b0};
            end
        end
        if (i_cmd.mul_lo) begin
            r_plox <= w_lox[62:30];
            r_ploy <= w_loy[62:30];
        end
        if (i_cmd.mul_hi) begin
            r_phix <= r_mmag[45:32] * r_qx;
            r_phiy <= r_mmag[45:32] * r_qy;
        end
        if (i_cmd.finish) begin
            r_out_vx  <= w_satx;
            r_out_vy  <= w_saty;
            r_out_idx <= r_hit ? w_adv : r_wp_idx;
            r_out_hit <= r_hit;
        end
    end

    assign o_status.out_full = r_out_valid;
    assign o_valid        = r_out_valid;
    assign o_new_vel_x    = r_out_vx;
    assign o_new_vel_y    = r_out_vy;
    assign o_target_index = r_out_idx;
    assign o_reached      = r_out_hit;

endmodule

`default_nettype wire

/* hw/rtl/waypoint_guidance_step_unit.sv */
// An accepted input beat runs the square, the 32-step square root, scaling,
// the 31-step dividers and the multiplies in turn; finish waits while a
// previous result is still held by output stall. No new input is taken
// until the item has finished, so only one item is in flight.
// Reset (synchronous, active low) restores register defaults and waypoint 1.
// ----------------------------------------------------------------------------
// Waypoint guidance step unit
// Steers a planar velocity toward the current corner of a square path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module waypoint_guidance_step_unit
    import wgs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic signed [31:0]    i_pos_x,
    input  wire logic signed [31:0]    i_pos_y,
    input  wire logic signed [31:0]    i_vel_x,
    input  wire logic signed [31:0]    i_vel_y,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic signed [31:0]         o_new_vel_x,
    output logic signed [31:0]         o_new_vel_y,
    output logic [IDX_W-1:0]           o_target_index,
    output logic                       o_reached,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    wgs_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_stall (i_stall),
        .i_status    (w_status),
        .o_stall     (o_stall),
        .o_cmd       (w_cmd)
    );

    wgs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_vel_x        (i_vel_x),
        .i_vel_y        (i_vel_y),
        .i_out_stall    (i_stall),
        .o_status       (w_status),
        .o_valid        (o_valid),
        .o_new_vel_x    (o_new_vel_x),
        .o_new_vel_y    (o_new_vel_y),
        .o_target_index (o_target_index),
        .o_reached      (o_reached)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("unit not busy after an accepted beat");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_target_index != '0 && o_target_index < IDX_W'(NUM_WAYPOINTS)))
        else $error("target index out of range");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> !o_stall)
        else $error("controller not idle after finishing an item");
`endif

endmodule

`default_nettype wire
